### src/lkv_pkg.sv
`timescale 1ns / 1ps
package lkv_pkg;

   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 31;
   localparam int DEF_VALUE_BITS = 31;

   localparam int             CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } lkv_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } lkv_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_get;
      logic out_blocked;
   } lkv_status_type;

endpackage

### src/lkv_req_if.sv
`timescale 1ns / 1ps
interface lkv_req_if #(
   parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

### src/lkv_rsp_if.sv
`timescale 1ns / 1ps
interface lkv_rsp_if #(
   parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

### src/lkv_ctrl.sv
`timescale 1ns / 1ps
module lkv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lkv_pkg::lkv_status_type status,
   output lkv_pkg::lkv_cmd_type    cmd
);

   lkv_pkg::lkv_state_type state_ff, state_in;
   logic                   stall;

   // a get cannot retire while the previous response is still unread
   assign stall = status.is_get && status.out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (req_valid) state_in = lkv_pkg::ST_COMPARE;
         end
         lkv_pkg::ST_COMPARE: begin
            state_in = lkv_pkg::ST_UPDATE;
         end
         lkv_pkg::ST_UPDATE: begin
            if (!stall) state_in = req_valid ? lkv_pkg::ST_COMPARE : lkv_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.compare = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         lkv_pkg::ST_COMPARE: begin
            cmd.compare = 1'b1;
         end
         lkv_pkg::ST_UPDATE: begin
            req_ready  = !stall;
            cmd.update = !stall;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load = req_valid && req_ready;
   end

endmodule

### src/lkv_dpath.sv
`timescale 1ns / 1ps
module lkv_dpath #(
   parameter int ENTRIES    = lkv_pkg::DEF_ENTRIES,
   parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lkv_pkg::lkv_cmd_type         cmd,
   output lkv_pkg::lkv_status_type      status,
   input  logic                         csr_write_enable,
   input  logic [lkv_pkg::CAP_BITS-1:0] csr_write_data,
   input  logic                         req_opcode,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic [VALUE_BITS-1:0]        req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [VALUE_BITS-1:0]        rsp_read_value
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > lkv_pkg::CAP_BITS) ? OCC_W : lkv_pkg::CAP_BITS;

   // request word
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   // entry state
   logic [KEY_BITS-1:0]   keys_ff  [ENTRIES];
   logic [IDX_W-1:0]      age_ff   [ENTRIES];
   logic [IDX_W-1:0]      age_in   [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [VALUE_BITS-1:0] val_mem  [ENTRIES];

   logic [lkv_pkg::CAP_BITS-1:0] cap_ff;

   // lookup result
   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [IDX_W-1:0]      hit_age_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;

   // response word
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;

   logic [ENTRIES-1:0] match;
   logic [IDX_W-1:0]   match_idx, match_age;
   logic [IDX_W-1:0]   victim_idx, free_idx, slot;
   logic [IDX_W-1:0]   oldest_age;
   logic [CMP_W-1:0]   cap_eff;
   logic               evict, do_put, do_insert;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   // parallel key compare; valid keys are distinct, so at most one match
   always_comb begin
      match_idx = '0;
      match_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == key_ff);
         if (match[i]) begin
            match_idx = match_idx | IDX_W'(i);
            match_age = match_age | age_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff     <= |match;
         hit_idx_ff <= match_idx;
         hit_age_ff <= match_age;
         rd_data_ff <= val_mem[match_idx];
      end
      if (mem_we) begin
         val_mem[mem_addr] <= val_ff;
      end
   end

   // ranks of valid entries are 0..occ-1, so the oldest holds occ-1
   assign oldest_age = IDX_W'(occ_ff - OCC_W'(1));

   always_comb begin
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (age_ff[i] == oldest_age)) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IDX_W'(i);
      end
   end

   assign do_put    = cmd.update && (op_ff == lkv_pkg::OP_PUT);
   assign evict     = CMP_W'(occ_ff) >= cap_eff;
   assign do_insert = do_put && !hit_ff;
   // evicted slot is reused for the new key
   assign slot      = evict ? victim_idx : free_idx;
   assign mem_we    = do_put;
   assign mem_addr  = hit_ff ? hit_idx_ff : slot;

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (cmd.update && hit_ff) begin
            if (IDX_W'(i) == hit_idx_ff) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < hit_age_ff)) begin
               age_in[i] = age_ff[i] + IDX_W'(1);
            end
         end else if (do_insert) begin
            if (IDX_W'(i) == slot) begin
               valid_in[i] = 1'b1;
               age_in[i]   = '0;
            end else if (valid_ff[i]) begin
               age_in[i] = age_ff[i] + IDX_W'(1);
            end
         end
      end
      if (do_insert && !evict) occ_in = occ_ff + OCC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= age_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_insert && (IDX_W'(i) == slot)) keys_ff[i] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update && (op_ff == lkv_pkg::OP_GET)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && (op_ff == lkv_pkg::OP_GET)) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? rd_data_ff : '0;
      end
   end

   assign status.is_get      = (op_ff == lkv_pkg::OP_GET);
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

### src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Flow: a get word's response is registered after the key compare state and the
//   recency/valid update state over the entry table. A new word is taken only in idle
//   or in the update state of the previous word; a get waits in that state while the response
//   register is still held by the sink.
// Reset: synchronous, active high; clears valid marks, ages, occupancy, and sets
//   capacity to 16. Key and value storage is not cleared; no clearing pass.
module lru_key_value_cache #(
   parameter int ENTRIES    = lkv_pkg::DEF_ENTRIES,
   parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [lkv_pkg::CAP_BITS-1:0] csr_write_data,
   lkv_req_if.sink                      req_chan,
   lkv_rsp_if.source                    rsp_chan
);

   lkv_pkg::lkv_cmd_type    cmd;
   lkv_pkg::lkv_status_type status;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_dpath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req_chan.opcode),
      .req_key          (req_chan.key),
      .req_value        (req_chan.value),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_hit          (rsp_chan.hit),
      .rsp_read_value   (rsp_chan.read_value)
   );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int ENTRIES        = lkv_pkg::DEF_ENTRIES;
   localparam int KEY_BITS       = lkv_pkg::DEF_KEY_BITS;
   localparam int VALUE_BITS     = lkv_pkg::DEF_VALUE_BITS;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 117;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [KEY_BITS-1:0]   KEY_MAX   = '1;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   typedef struct {
      logic                  op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cache_request_type;

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                         csr_write_enable;
   logic [lkv_pkg::CAP_BITS-1:0] csr_write_data;

   lkv_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_if ();
   lkv_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

   lru_key_value_cache #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_if.sink),
      .rsp_chan        (rsp_if.source)
   );

   always #5 clock = ~clock;

   // Shadow copy of the cache: contents, LRU ranks (0 = most recent), fill level.
   logic [KEY_BITS-1:0]          lru_keys   [ENTRIES];
   logic [VALUE_BITS-1:0]        lru_values [ENTRIES];
   bit                           lru_valid  [ENTRIES];
   int unsigned                  lru_age    [ENTRIES];
   int unsigned                  lru_fill     = 0;
   logic [lkv_pkg::CAP_BITS-1:0] lru_capacity = lkv_pkg::CAP_RESET;

   cache_request_type pending_requests [$];
   lookup_result_type expected_lookups [$];

   int gap_mode   = 0;
   int stall_mode = 0;
   int gap_left   = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int requests_accepted = 0;
   int lookups_checked   = 0;
   int hits_seen         = 0;
   int settings_written  = 0;

   function automatic int effective_capacity(logic [lkv_pkg::CAP_BITS-1:0] cap);
      if (cap == 0) return 1;
      if (cap > ENTRIES) return ENTRIES;
      return int'(cap);
   endfunction

   // 0: no waits, 1: uniform 0..19, 2: mostly back to back with an occasional wait
   function automatic int draw_wait(int mode);
      if (mode == 0) return 0;
      if (mode == 1) return $urandom_range(0, 19);
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
   endfunction

   task automatic lru_touch(int e);
      for (int i = 0; i < ENTRIES; i++)
         if (lru_valid[i] && i != e && lru_age[i] < lru_age[e]) lru_age[i]++;
      lru_age[e] = 0;
   endtask

   task automatic lru_access(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
      int found;
      int victim;
      int slot;
      lookup_result_type res;
      found  = -1;
      victim = -1;
      slot   = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && lru_valid[i] && lru_keys[i] == key) found = i;
      if (op == lkv_pkg::OP_GET) begin
         res.hit        = 1'b0;
         res.read_value = '0;
         if (found >= 0) begin
            lru_touch(found);
            res.hit        = 1'b1;
            res.read_value = lru_values[found];
         end
         expected_lookups.push_back(res);
      end else if (found >= 0) begin
         lru_values[found] = value;
         lru_touch(found);
      end else begin
         // full (or capacity lowered under the fill level): drop only the oldest one
         if (lru_fill >= effective_capacity(lru_capacity)) begin
            for (int i = 0; i < ENTRIES; i++)
               if (lru_valid[i] && (victim < 0 || lru_age[i] > lru_age[victim])) victim = i;
            if (victim >= 0) begin
               lru_valid[victim] = 1'b0;
               lru_fill--;
            end
         end
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !lru_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (lru_valid[i]) lru_age[i]++;
            lru_keys[slot]   = key;
            lru_values[slot] = value;
            lru_valid[slot]  = 1'b1;
            lru_age[slot]    = 0;
            lru_fill++;
         end
      end
   endtask

   task automatic push_request(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
      cache_request_type r;
      r.op    = op;
      r.key   = key;
      r.value = value;
      pending_requests.push_back(r);
   endtask

   // Block until every word is through and every lookup answered, then let puts settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_lookups.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(logic [lkv_pkg::CAP_BITS-1:0] cap);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lru_capacity = cap;
      settings_written++;
      @(negedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin : request_driver
      cache_request_type issue_req;
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.opcode <= lkv_pkg::OP_GET;
         req_if.key    <= '0;
         req_if.value  <= '0;
         gap_left      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            lru_access(req_if.opcode, req_if.key, req_if.value);
            requests_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (pending_requests.size() != 0) begin
               issue_req      = pending_requests.pop_front();
               req_if.valid  <= 1'b1;
               req_if.opcode <= issue_req.op;
               req_if.key    <= issue_req.key;
               req_if.value  <= issue_req.value;
               gap_left      <= draw_wait(gap_mode);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin : response_monitor
      lookup_result_type exp_res;
      int stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (expected_lookups.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word: expected none, actual hit=%0b read_value=%0h",
                     $time, rsp_if.hit, rsp_if.read_value);
         end else begin
            exp_res = expected_lookups.pop_front();
            lookups_checked++;
            if (exp_res.hit) hits_seen++;
            if (rsp_if.hit !== exp_res.hit) begin
               error_count++;
               $display("%0t: hit mismatch: expected %0b actual %0b",
                        $time, exp_res.hit, rsp_if.hit);
            end
            if (rsp_if.read_value !== exp_res.read_value) begin
               error_count++;
               $display("%0t: read_value mismatch: expected %0h actual %0h",
                        $time, exp_res.read_value, rsp_if.read_value);
            end
         end
         stall = draw_wait(stall_mode);
         stall_left   <= stall;
         rsp_if.ready <= (stall == 0);
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [lkv_pkg::CAP_BITS-1:0] cap_plan [9];
      logic [lkv_pkg::CAP_BITS-1:0] cap;
      logic [KEY_BITS-1:0]          key_pool [$];
      logic [KEY_BITS-1:0]          base_key;
      logic [KEY_BITS-1:0]          key;
      logic [VALUE_BITS-1:0]        value;
      int pool_size;
      int pick;

      // 16 then 3 drops the capacity under the fill level
      cap_plan = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd20, 5'd9};

      csr_write_enable = 1'b0;
      csr_write_data   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty lookup, key/value extremes, near-miss key, overwrite
      push_request(lkv_pkg::OP_GET, '0, '0);
      push_request(lkv_pkg::OP_PUT, '0, VALUE_MAX);
      push_request(lkv_pkg::OP_GET, '0, '0);
      push_request(lkv_pkg::OP_PUT, KEY_MAX, '0);
      push_request(lkv_pkg::OP_GET, KEY_MAX, VALUE_MAX);
      push_request(lkv_pkg::OP_GET, KEY_MAX ^ KEY_BITS'(1), '0);
      push_request(lkv_pkg::OP_PUT, '0, 31'h2AAA_AAAA);
      push_request(lkv_pkg::OP_GET, '0, '0);
      push_request(lkv_pkg::OP_GET, 31'd1, '0);
      wait_drained();

      // directed eviction at capacity 2
      set_capacity(5'd2);
      push_request(lkv_pkg::OP_PUT, 31'd10, 31'h5555_5555);
      push_request(lkv_pkg::OP_GET, KEY_MAX, '0);
      push_request(lkv_pkg::OP_GET, '0, '0);
      push_request(lkv_pkg::OP_GET, 31'd10, '0);
      push_request(lkv_pkg::OP_PUT, KEY_MAX, VALUE_MAX);
      push_request(lkv_pkg::OP_GET, '0, '0);
      push_request(lkv_pkg::OP_GET, KEY_MAX, '0);
      push_request(lkv_pkg::OP_PUT, 31'd10, 31'd7);
      push_request(lkv_pkg::OP_GET, 31'd10, '0);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         cap = (ph < 9) ? cap_plan[ph] : lkv_pkg::CAP_BITS'($urandom_range(0, 31));
         set_capacity(cap);
         gap_mode   = $urandom_range(0, 2);
         stall_mode = $urandom_range(0, 2);

         // key set of 1 to capacity+4 keys so hits and evictions mix
         pool_size = $urandom_range(1, effective_capacity(cap) + 4);
         base_key  = KEY_BITS'($urandom);
         key_pool.delete();
         for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 3))
               0: key = KEY_BITS'($urandom);
               1: key = base_key ^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
               2: key = $urandom_range(0, 1) ? KEY_MAX : '0;
               default: key = base_key + KEY_BITS'(i);
            endcase
            key_pool.push_back(key);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick  = $urandom_range(0, 99);
            key   = key_pool[$urandom_range(0, pool_size - 1)];
            value = VALUE_BITS'($urandom);
            if ($urandom_range(0, 15) == 0) value = $urandom_range(0, 1) ? VALUE_MAX : '0;
            if (pick < 45)
               push_request(lkv_pkg::OP_PUT, key, value);
            else if (pick < 92)
               push_request(lkv_pkg::OP_GET, key, value);
            else if (pick < 96)
               push_request(lkv_pkg::OP_GET, KEY_BITS'($urandom), value);
            else
               push_request(lkv_pkg::OP_PUT, KEY_BITS'($urandom), value);
         end
         wait_drained();
      end

      $display("Covered %0d requests over %0d capacity settings, including 0 and 31.",
               requests_accepted, settings_written);
      $display("Checked %0d lookups, %0d of them hits.", lookups_checked, hits_seen);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### lru_key_value_cache.f
src/lkv_pkg.sv
src/lkv_req_if.sv
src/lkv_rsp_if.sv
src/lkv_ctrl.sv
src/lkv_dpath.sv
src/lru_key_value_cache.sv
verif/tb_top.sv
